FILE: rtl/rtw_pkg.sv
// Package for the refreshable timer wheel: sizes, command and status codes,
// slot entry and control structs shared by all modules.
// No dependencies.
package rtw_pkg;

    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CMD_W       = 2;
    localparam int ID_W        = 64;
    localparam int DLY_W       = 11;
    localparam int STAT_W      = 3;

    localparam logic [DLY_W-1:0]  WHEEL_RESET = DLY_W'(30);
    localparam logic [DLY_W-1:0]  WHEEL_MAX   = DLY_W'(1024);
    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(TIMER_SLOTS - 1);

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_REFRESH,
        CMD_CANCEL,
        CMD_TICK
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_REJECTED,
        ST_FULL,
        ST_TICK_DONE
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [DLY_W-1:0] dly;
        logic [DLY_W-1:0] rem;
        logic             cancelled;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_wr;

    typedef struct packed {
        logic             match;
        logic             free;
        logic             expire;
        logic             fire;
        logic [DLY_W-1:0] rem_dec;
    } t_probe;

endpackage

FILE: rtl/rtw_in_if.sv
// Command channel of the timer wheel: valid/ready plus one command beat.
// Depends on rtw_pkg.
interface rtw_in_if;
    logic                       valid;
    logic                       ready;
    logic [rtw_pkg::CMD_W-1:0]  cmd;
    logic [rtw_pkg::ID_W-1:0]   timer_id;
    logic [rtw_pkg::DLY_W-1:0]  delay;

    modport source (output valid, cmd, timer_id, delay, input ready);
    modport sink   (input valid, cmd, timer_id, delay, output ready);
endinterface

FILE: rtl/rtw_out_if.sv
// Result channel of the timer wheel: valid/ready plus one result beat.
// Depends on rtw_pkg.
interface rtw_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [rtw_pkg::STAT_W-1:0] status;
    logic [rtw_pkg::ID_W-1:0]   expired_id;
    logic                       last;

    modport source (output valid, kind, status, expired_id, last, input ready);
    modport sink   (input valid, kind, status, expired_id, last, output ready);
endinterface

FILE: rtl/rtw_slot_store.sv
// Timer slot table: one write port and one read port, valid bits in flops.
// Depends on rtw_pkg.
module rtw_slot_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rtw_pkg::t_wr                 i_wr,
    input  logic [rtw_pkg::SLOT_W-1:0]   i_rd_addr,
    output rtw_pkg::t_entry              o_rd
);

    logic                      r_valid     [rtw_pkg::TIMER_SLOTS];
    logic [rtw_pkg::ID_W-1:0]  r_id        [rtw_pkg::TIMER_SLOTS];
    logic [rtw_pkg::DLY_W-1:0] r_dly       [rtw_pkg::TIMER_SLOTS];
    logic [rtw_pkg::DLY_W-1:0] r_rem       [rtw_pkg::TIMER_SLOTS];
    logic                      r_cancelled [rtw_pkg::TIMER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rtw_pkg::TIMER_SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= i_wr.data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_id[i_wr.addr]        <= i_wr.data.id;
            r_dly[i_wr.addr]       <= i_wr.data.dly;
            r_rem[i_wr.addr]       <= i_wr.data.rem;
            r_cancelled[i_wr.addr] <= i_wr.data.cancelled;
        end
    end

    assign o_rd.valid     = r_valid[i_rd_addr];
    assign o_rd.id        = r_id[i_rd_addr];
    assign o_rd.dly       = r_dly[i_rd_addr];
    assign o_rd.rem       = r_rem[i_rd_addr];
    assign o_rd.cancelled = r_cancelled[i_rd_addr];

endmodule

FILE: rtl/rtw_scan_unit.sv
// Shared compare/decrement unit: one slot per cycle during a scan, held while a tick stalls.
// Depends on rtw_pkg.
module rtw_scan_unit (
    input  rtw_pkg::t_entry            i_entry,
    input  logic [rtw_pkg::ID_W-1:0]   i_id,
    output rtw_pkg::t_probe            o_probe
);

    always_comb begin
        o_probe.match   = i_entry.valid && (i_entry.id == i_id);
        o_probe.free    = !i_entry.valid;
        o_probe.expire  = i_entry.valid && (i_entry.rem <= rtw_pkg::DLY_W'(1));
        o_probe.fire    = o_probe.expire && !i_entry.cancelled;
        o_probe.rem_dec = i_entry.rem - rtw_pkg::DLY_W'(1);
    end

endmodule

FILE: rtl/refreshable_timer_wheel_unit.sv
// Refreshable timer wheel top level: sequencer, output register, wheel size.
// Depends on rtw_pkg, rtw_in_if, rtw_out_if, rtw_slot_store, rtw_scan_unit.
//
// Usage:
//   i_in carries commands (add, refresh, cancel, tick) with timer id and delay.
//   o_out carries results; every command ends with one beat that has last set.
//   i_cfg_we/i_cfg_wdata write wheel_size; write only while the block is idle.
// Sequence:
//   Each command but a rejected add walks all TIMER_SLOTS entries through one
//   compare/decrement unit, one entry per cycle unless a tick scan stalls on
//   backpressure. Add, refresh and cancel go from the scan through the apply
//   state to the result beat; an add with a rejected delay skips the scan. A
//   tick goes from the scan to its final beat, waiting on the receiver for expiry beats.
//   A new command is accepted only after the previous last beat is loaded.
// Reset: all timers are freed, wheel_size returns to 30, o_out goes idle.
// Backpressure: results sit in an output register; while it is full and not
//   taken, the tick scan holds at an expiring uncancelled entry and nothing is lost.
module refreshable_timer_wheel_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rtw_pkg::DLY_W-1:0]   i_cfg_wdata,
    rtw_in_if.sink                      i_in,
    rtw_out_if.source                   o_out
);

    rtw_pkg::t_state           r_state, n_state;
    logic [rtw_pkg::DLY_W-1:0] r_wheel;
    rtw_pkg::t_cmd             r_cmd;
    logic [rtw_pkg::ID_W-1:0]  r_id;
    logic [rtw_pkg::DLY_W-1:0] r_dly;
    logic [rtw_pkg::SLOT_W-1:0] r_idx;
    logic                      r_found;
    logic [rtw_pkg::SLOT_W-1:0] r_hit;
    logic                      r_has_free;
    logic [rtw_pkg::SLOT_W-1:0] r_free;
    rtw_pkg::t_status          r_status;

    logic                       r_o_valid;
    logic                       r_o_kind;
    rtw_pkg::t_status           r_o_status;
    logic [rtw_pkg::ID_W-1:0]   r_o_id;
    logic                       r_o_last;

    logic [rtw_pkg::DLY_W-1:0]  w_size;
    logic                       w_accept;
    logic                       w_reject;
    logic                       w_out_can;
    logic                       w_in_ready;
    logic                       w_adv;
    rtw_pkg::t_wr               w_wr;
    logic [rtw_pkg::SLOT_W-1:0] w_rd_addr;
    rtw_pkg::t_entry            w_rd;
    rtw_pkg::t_probe            w_probe;
    rtw_pkg::t_status           w_status;
    logic                       w_out_load;
    logic                       w_out_kind;
    rtw_pkg::t_status           w_out_status;
    logic [rtw_pkg::ID_W-1:0]   w_out_id;
    logic                       w_out_last;

    rtw_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd)
    );

    rtw_scan_unit u_scan (
        .i_entry (w_rd),
        .i_id    (r_id),
        .o_probe (w_probe)
    );

    // Effective wheel size: 0 acts as 1, anything above 1024 as 1024.
    always_comb begin
        if (r_wheel == '0) begin
            w_size = rtw_pkg::DLY_W'(1);
        end else if (r_wheel > rtw_pkg::WHEEL_MAX) begin
            w_size = rtw_pkg::WHEEL_MAX;
        end else begin
            w_size = r_wheel;
        end
    end

    assign w_out_can = !r_o_valid || o_out.ready;
    assign w_accept  = i_in.valid && w_in_ready;
    assign w_reject  = (rtw_pkg::t_cmd'(i_in.cmd) == rtw_pkg::CMD_ADD) && (i_in.delay > w_size);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtw_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_reject ? rtw_pkg::S_RESP : rtw_pkg::S_SCAN;
                end
            end
            rtw_pkg::S_SCAN: begin
                if (w_adv && (r_idx == rtw_pkg::SLOT_LAST)) begin
                    n_state = (r_cmd == rtw_pkg::CMD_TICK) ? rtw_pkg::S_RESP
                                                           : rtw_pkg::S_APPLY;
                end
            end
            rtw_pkg::S_APPLY: begin
                n_state = rtw_pkg::S_RESP;
            end
            rtw_pkg::S_RESP: begin
                if (w_out_can) begin
                    n_state = rtw_pkg::S_IDLE;
                end
            end
            default: n_state = rtw_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        w_in_ready   = 1'b0;
        w_adv        = 1'b0;
        w_rd_addr    = r_idx;
        w_wr.we      = 1'b0;
        w_wr.addr    = r_idx;
        w_wr.data    = w_rd;
        w_status     = rtw_pkg::ST_OK;
        w_out_load   = 1'b0;
        w_out_kind   = rtw_pkg::KIND_STATUS;
        w_out_status = rtw_pkg::ST_OK;
        w_out_id     = r_id;
        w_out_last   = 1'b1;
        unique case (r_state)
            rtw_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
            end
            rtw_pkg::S_SCAN: begin
                if (r_cmd == rtw_pkg::CMD_TICK) begin
                    // hold on an expiring entry until its beat fits
                    w_adv = !(w_probe.fire && !w_out_can);
                    if (w_adv && w_rd.valid) begin
                        w_wr.we = 1'b1;
                        if (w_probe.expire) begin
                            w_wr.data.valid = 1'b0;
                            w_wr.data.rem   = '0;
                        end else begin
                            w_wr.data.rem = w_probe.rem_dec;
                        end
                    end
                    if (w_adv && w_probe.fire) begin
                        w_out_load = 1'b1;
                        w_out_kind = rtw_pkg::KIND_EXPIRY;
                        w_out_id   = w_rd.id;
                        w_out_last = 1'b0;
                    end
                end else begin
                    w_adv = 1'b1;
                end
            end
            rtw_pkg::S_APPLY: begin
                w_rd_addr = r_found ? r_hit : r_free;
                w_wr.addr = w_rd_addr;
                case (r_cmd)
                    rtw_pkg::CMD_ADD: begin
                        if (r_found || r_has_free) begin
                            w_wr.we             = 1'b1;
                            w_wr.data.valid     = 1'b1;
                            w_wr.data.id        = r_id;
                            w_wr.data.dly       = r_dly;
                            w_wr.data.rem       = r_dly;
                            w_wr.data.cancelled = 1'b0;
                        end else begin
                            w_status = rtw_pkg::ST_FULL;
                        end
                    end
                    rtw_pkg::CMD_REFRESH: begin
                        if (r_found) begin
                            w_wr.we       = 1'b1;
                            w_wr.data.rem = w_rd.dly;
                        end else begin
                            w_status = rtw_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            w_wr.we             = 1'b1;
                            w_wr.data.cancelled = 1'b1;
                        end else begin
                            w_status = rtw_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            rtw_pkg::S_RESP: begin
                w_out_load   = w_out_can;
                w_out_status = r_status;
                w_out_id     = (r_cmd == rtw_pkg::CMD_TICK) ? '0 : r_id;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rtw_pkg::S_IDLE;
            r_wheel   <= rtw_pkg::WHEEL_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wheel <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Command context and scan results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= rtw_pkg::t_cmd'(i_in.cmd);
            r_id       <= i_in.timer_id;
            r_dly      <= (i_in.delay == '0) ? w_size : i_in.delay;
            r_status   <= w_reject ? rtw_pkg::ST_REJECTED : rtw_pkg::ST_TICK_DONE;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
        end else if (r_state == rtw_pkg::S_SCAN) begin
            if (w_adv) begin
                r_idx <= r_idx + rtw_pkg::SLOT_W'(1);
                if (w_probe.match && !r_found) begin
                    r_found <= 1'b1;
                    r_hit   <= r_idx;
                end
                if (w_probe.free && !r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= r_idx;
                end
            end
        end else if (r_state == rtw_pkg::S_APPLY) begin
            r_status <= w_status;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_kind   <= w_out_kind;
            r_o_status <= w_out_status;
            r_o_id     <= w_out_id;
            r_o_last   <= w_out_last;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.kind       = r_o_kind;
    assign o_out.status     = r_o_status;
    assign o_out.expired_id = r_o_id;
    assign o_out.last       = r_o_last;

endmodule
